>>> hdl/cdq_pkg.sv
// Shared constants and types for the circular deque unit.
package cdq_pkg;

   localparam int DEPTH  = 8;
   localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int DATA_W = 32;
   localparam int CMD_W  = 3;
   localparam int STAT_W = 2;

   typedef logic [PTR_W-1:0]  ptr_type;
   typedef logic [DATA_W-1:0] data_type;
   typedef logic [CMD_W-1:0]  cmd_type;
   typedef logic [STAT_W-1:0] stat_type;

   localparam cmd_type CMD_PUSH_FRONT = 3'd0;
   localparam cmd_type CMD_PUSH_REAR  = 3'd1;
   localparam cmd_type CMD_POP_FRONT  = 3'd2;
   localparam cmd_type CMD_POP_REAR   = 3'd3;
   localparam cmd_type CMD_PEEK_FRONT = 3'd4;
   localparam cmd_type CMD_PEEK_REAR  = 3'd5;

   localparam stat_type ST_OK        = 2'd0;
   localparam stat_type ST_OVERFLOW  = 2'd1;
   localparam stat_type ST_UNDERFLOW = 2'd2;

   localparam ptr_type PTR_LAST = ptr_type'(DEPTH - 1);

   function automatic ptr_type wrap_inc(input ptr_type p);
      wrap_inc = (p == PTR_LAST) ? '0 : ptr_type'(p + 1'b1);
   endfunction

   function automatic ptr_type wrap_dec(input ptr_type p);
      wrap_dec = (p == '0) ? PTR_LAST : ptr_type'(p - 1'b1);
   endfunction

endpackage

>>> hdl/cdq_ram.sv
// Generic single-port RAM with registered read data.
module cdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] addr,
   input  logic [WIDTH-1:0]  wdata,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end else begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> hdl/circular_deque_unit.sv
// Circular deque: pointer control around a slot RAM.
// A result strobes in the cycle after its transaction is accepted.
// Throughput: one transaction per cycle while busy is low; the slot RAM takes one read or one write per command.
// busy is high during reset and in the cycle after it, otherwise low.
// Reset empties the queue and zeroes both pointers; slot contents are left as they are.
// Results cannot be stalled by the receiver.
module circular_deque_unit
   import cdq_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [CMD_W-1:0]         req_cmd,
   input  logic signed [DATA_W-1:0] req_push_value,
   output logic                     rsp_strobe,
   output logic signed [DATA_W-1:0] rsp_read_value,
   output logic [STAT_W-1:0]        rsp_status
);

   ptr_type  head_ff, head_in;
   ptr_type  tail_ff, tail_in;
   logic     empty_ff, empty_in;
   logic     busy_ff;
   logic     strobe_ff;
   stat_type status_ff, status_in;
   logic     rd_sel_ff, rd_sel_in;

   logic     accept;
   logic     full;
   logic     ram_we;
   ptr_type  ram_addr;
   data_type ram_rdata;

   assign accept = start && !busy;
   assign full   = !empty_ff && (wrap_inc(tail_ff) == head_ff);

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      empty_in  = empty_ff;
      status_in = ST_OK;
      rd_sel_in = 1'b0;
      ram_we    = 1'b0;
      ram_addr  = head_ff;
      if (accept) begin
         case (req_cmd)
            CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
               if (full) begin
                  status_in = ST_OVERFLOW;
               end else if (empty_ff) begin
                  head_in  = '0;
                  tail_in  = '0;
                  empty_in = 1'b0;
                  ram_we   = 1'b1;
                  ram_addr = '0;
               end else if (req_cmd == CMD_PUSH_FRONT) begin
                  head_in  = wrap_dec(head_ff);
                  ram_we   = 1'b1;
                  ram_addr = wrap_dec(head_ff);
               end else begin
                  tail_in  = wrap_inc(tail_ff);
                  ram_we   = 1'b1;
                  ram_addr = wrap_inc(tail_ff);
               end
            end
            CMD_POP_FRONT, CMD_POP_REAR: begin
               if (empty_ff) begin
                  status_in = ST_UNDERFLOW;
               end else begin
                  rd_sel_in = 1'b1;
                  ram_addr  = (req_cmd == CMD_POP_FRONT) ? head_ff : tail_ff;
                  if (head_ff == tail_ff) begin
                     empty_in = 1'b1;
                     head_in  = '0;
                     tail_in  = '0;
                  end else if (req_cmd == CMD_POP_FRONT) begin
                     head_in = wrap_inc(head_ff);
                  end else begin
                     tail_in = wrap_dec(tail_ff);
                  end
               end
            end
            CMD_PEEK_FRONT, CMD_PEEK_REAR: begin
               if (empty_ff) begin
                  status_in = ST_UNDERFLOW;
               end else begin
                  rd_sel_in = 1'b1;
                  ram_addr  = (req_cmd == CMD_PEEK_FRONT) ? head_ff : tail_ff;
               end
            end
            default: begin
               status_in = ST_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         tail_ff   <= '0;
         empty_ff  <= 1'b1;
         busy_ff   <= 1'b1;
         strobe_ff <= 1'b0;
         rd_sel_ff <= 1'b0;
      end else begin
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         empty_ff  <= empty_in;
         busy_ff   <= 1'b0;
         strobe_ff <= accept;
         rd_sel_ff <= rd_sel_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
   end

   cdq_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_slots (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (data_type'(req_push_value)),
      .rdata (ram_rdata)
   );

   assign busy           = busy_ff || reset;
   assign rsp_strobe     = strobe_ff;
   assign rsp_status     = status_ff;
   assign rsp_read_value = rd_sel_ff ? $signed(ram_rdata) : '0;

endmodule

>>> hdl/cdq_checker.sv
// Port-level checks for the circular deque unit, with bind.
module cdq_checker
   import cdq_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     start,
   input logic                     busy,
   input logic [CMD_W-1:0]         req_cmd,
   input logic                     rsp_strobe,
   input logic signed [DATA_W-1:0] rsp_read_value,
   input logic [STAT_W-1:0]        rsp_status
);

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_strobe)
      else $error("accepted transaction gave no result");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |=> !rsp_strobe)
      else $error("result without a transaction");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != ST_OK) |-> (rsp_read_value == '0))
      else $error("refused transaction returned data");

   a_push_zero: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_cmd == CMD_PUSH_FRONT || req_cmd == CMD_PUSH_REAR))
      |=> (rsp_read_value == '0 && rsp_status != ST_UNDERFLOW))
      else $error("push returned data or underflow");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_status == ST_OK || rsp_status == ST_OVERFLOW ||
                      rsp_status == ST_UNDERFLOW))
      else $error("undefined status code");

endmodule

bind circular_deque_unit cdq_checker u_cdq_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_cmd        (req_cmd),
   .rsp_strobe     (rsp_strobe),
   .rsp_read_value (rsp_read_value),
   .rsp_status     (rsp_status)
);
